>>> design/sdfs_pkg.sv
// ----------------------------------------------------------------------------
// sdfs_pkg
// Shared types, constants and lookup functions for the seven-segment display
// frame sender.
// ----------------------------------------------------------------------------
package sdfs_pkg;

  // Command kinds.
  localparam logic KIND_DIGIT  = 1'b0;
  localparam logic KIND_BRIGHT = 1'b1;

  // Fixed bytes of the display driver protocol.
  localparam logic [7:0] ADDR_BRIGHT = 8'h18;
  localparam logic [7:0] DOT_MASK    = 8'h80;

  // Line framing: start, eight data bits, odd parity, stop.
  localparam int unsigned BYTE_BITS  = 11;
  localparam int unsigned FRAME_BITS = 2 * BYTE_BITS;
  localparam int unsigned BIT_CNT_W  = $clog2(FRAME_BITS);

  // Default depth of the queue between classifier and serializer.
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // One command reduced to the two bytes that go on the line.
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
  } sdfs_frame_t;

  // Head of the queue as seen by the serializer.
  typedef struct packed {
    logic        avail;
    sdfs_frame_t frame;
  } sdfs_q_head_t;

  // Segment pattern for a glyph index; the last index is blank.
  function automatic logic [7:0] glyph(input logic [4:0] idx);
    logic [7:0] seg;
    case (idx)
      5'd0:    seg = 8'h3f;
      5'd1:    seg = 8'h06;
      5'd2:    seg = 8'h5b;
      5'd3:    seg = 8'h4f;
      5'd4:    seg = 8'h66;
      5'd5:    seg = 8'h6d;
      5'd6:    seg = 8'h7d;
      5'd7:    seg = 8'h07;
      5'd8:    seg = 8'h7f;
      5'd9:    seg = 8'h6f;
      5'd10:   seg = 8'h77;
      5'd11:   seg = 8'h7c;
      5'd12:   seg = 8'h58;
      5'd13:   seg = 8'h5e;
      5'd14:   seg = 8'h79;
      5'd15:   seg = 8'h71;
      5'd16:   seg = 8'h6f;
      5'd17:   seg = 8'h76;
      5'd18:   seg = 8'h04;
      5'd19:   seg = 8'h38;
      5'd20:   seg = 8'h54;
      5'd21:   seg = 8'h5c;
      5'd22:   seg = 8'h73;
      5'd23:   seg = 8'h50;
      5'd24:   seg = 8'h6d;
      5'd25:   seg = 8'h78;
      5'd26:   seg = 8'h1c;
      5'd27:   seg = 8'h3e;
      5'd28:   seg = 8'h00;
      5'd29:   seg = 8'h6e;
      5'd30:   seg = 8'h40;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Grid address for positions 1 to 4 (position minus one as index).
  function automatic logic [7:0] grid_addr(input logic [1:0] idx);
    logic [7:0] a;
    case (idx)
      2'd0:    a = 8'h08;
      2'd1:    a = 8'h88;
      2'd2:    a = 8'h48;
      default: a = 8'hc8;
    endcase
    return a;
  endfunction

endpackage

>>> design/sdfs_if.sv
// ----------------------------------------------------------------------------
// sdfs_if
// Valid/ready channels of the frame sender: the command channel and the
// serial line channel.
// ----------------------------------------------------------------------------
interface sdfs_cmd_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] digit_value;
  logic [2:0] position;
  logic       dot;
  logic [2:0] current_level;
  logic [3:0] duty_level;

  modport source (output valid, kind, digit_value, position, dot, current_level,
                  duty_level, input ready);
  modport sink (input valid, kind, digit_value, position, dot, current_level,
                duty_level, output ready);
endinterface

interface sdfs_line_if;
  logic valid;
  logic ready;
  logic line_level;
  logic last;

  modport source (output valid, line_level, last, input ready);
  modport sink (input valid, line_level, last, output ready);
endinterface

>>> design/segment_display_frame_sender.sv
// A sending command is registered in the queue and then loaded into the
// serializer shift register before its first line bit shows; commands to
// an invalid position produce nothing. Throughput: 22 output beats per
// command, one per cycle while the line is ready, paced by the bit serializer.
// Reset: synchronous, active high; the queue and serializer return to empty.
// ----------------------------------------------------------------------------
// segment_display_frame_sender
// Top level: classifier, frame queue and line serializer.
// ----------------------------------------------------------------------------
module segment_display_frame_sender import sdfs_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sdfs_cmd_if.sink    cmd,
  sdfs_line_if.source line
);

  logic         push;
  logic         full;
  logic         pop;
  sdfs_frame_t  frame;
  sdfs_q_head_t head;

  // Classify incoming commands.
  sdfs_front u_front (
    .cmd   (cmd),
    .full  (full),
    .push  (push),
    .frame (frame)
  );

  // Decouple classifier and serializer.
  sdfs_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_frame (frame),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

  // Serialize frames onto the line.
  sdfs_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .line (line)
  );

endmodule

>>> design/sdfs_front.sv
// ----------------------------------------------------------------------------
// sdfs_front
// Command classifier: accepts command beats, drops digit writes to a
// position outside the grid and builds the address and data bytes.
// ----------------------------------------------------------------------------
module sdfs_front import sdfs_pkg::*; (
  sdfs_cmd_if.sink    cmd,
  input  logic        full,
  output logic        push,
  output sdfs_frame_t frame
);

  logic       send;
  logic [7:0] digit_data;
  logic [7:0] bright_data;
  logic [2:0] pos_m1;

  // A command is taken whenever the queue has room.
  assign cmd.ready = !full;

  // Digit write bytes.
  assign pos_m1     = cmd.position - 3'd1;
  assign digit_data = glyph(cmd.digit_value) | (cmd.dot ? DOT_MASK : 8'h00);

  // Brightness byte: reversed duty on top, reversed current below, bit 0 clear.
  assign bright_data = {cmd.duty_level[0], cmd.duty_level[1], cmd.duty_level[2],
                        cmd.duty_level[3], cmd.current_level[0],
                        cmd.current_level[1], cmd.current_level[2], 1'b0};

  // Classify and select the frame.
  always_comb begin
    if (cmd.kind == KIND_BRIGHT) begin
      send       = 1'b1;
      frame.addr = ADDR_BRIGHT;
      frame.data = bright_data;
    end else begin
      send       = (cmd.position >= 3'd1) && (cmd.position <= 3'd4);
      frame.addr = grid_addr(pos_m1[1:0]);
      frame.data = digit_data;
    end
  end

  assign push = cmd.valid && !full && send;

endmodule

>>> design/sdfs_queue.sv
// ----------------------------------------------------------------------------
// sdfs_queue
// Small register queue of pending frames between the classifier and the
// serializer.
// ----------------------------------------------------------------------------
module sdfs_queue import sdfs_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  sdfs_frame_t  wr_frame,
  output logic         full,
  input  logic         pop,
  output sdfs_q_head_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sdfs_frame_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.avail = (count != '0);
  assign head.frame = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.avail;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_frame;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/sdfs_back.sv
// ----------------------------------------------------------------------------
// sdfs_back
// Line serializer: expands a frame into 22 line bits (two 8-O-1 bytes) and
// presents one bit per beat from a shift register.
// ----------------------------------------------------------------------------
module sdfs_back import sdfs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  sdfs_q_head_t head,
  output logic         pop,
  sdfs_line_if.source  line
);

  logic                  busy;
  logic [FRAME_BITS-1:0] bits;
  logic [BIT_CNT_W-1:0]  cnt;
  logic                  at_end;
  logic                  beat;
  logic                  load;
  logic [FRAME_BITS-1:0] head_bits;

  // Line bits of one byte, first bit in the LSB.
  function automatic logic [BYTE_BITS-1:0] byte_bits(input logic [7:0] b);
    return {1'b1, ~^b, b, 1'b0};
  endfunction

  assign head_bits = {byte_bits(head.frame.data), byte_bits(head.frame.addr)};
  assign at_end    = (cnt == BIT_CNT_W'(FRAME_BITS - 1));
  assign beat      = busy && line.ready;
  assign load      = head.avail && (!busy || (beat && at_end));
  assign pop       = load;

  assign line.valid      = busy;
  assign line.line_level = bits[0];
  assign line.last       = at_end;

  // Control: busy flag and bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (beat) begin
      busy <= !at_end;
      cnt  <= at_end ? '0 : cnt + 1'b1;
    end
  end

  // Shift register of pending line bits.
  always_ff @(posedge clk) begin
    if (load) begin
      bits <= head_bits;
    end else if (beat) begin
      bits <= {1'b0, bits[FRAME_BITS-1:1]};
    end
  end

endmodule

>>> design/sdfs_checker.sv
// ----------------------------------------------------------------------------
// sdfs_checker
// Port-level checks of the line channel of the frame sender.
// ----------------------------------------------------------------------------
module sdfs_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic out_level,
  input logic out_last
);

  // The line is idle right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("line valid right after reset");

  // A stalled beat holds its bit.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_level) && $stable(out_last)))
    else $error("stalled line beat changed");

  // Two frame ends never follow one another.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !(out_valid && out_last))
    else $error("frame end repeated");

  // The beat after a frame end is a start bit or nothing.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> (!out_valid || !out_level))
    else $error("missing start bit after frame end");

endmodule

bind segment_display_frame_sender sdfs_checker u_sdfs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (line.valid),
  .out_ready (line.ready),
  .out_level (line.line_level),
  .out_last  (line.last)
);
